FILE: rtl/uart_hex_frame_receiver_top_defines.svh
// Assertion macros for the frame receiver
`ifndef UART_HEX_FRAME_RECEIVER_TOP_DEFINES_SVH
`define UART_HEX_FRAME_RECEIVER_TOP_DEFINES_SVH

// clocked check, quiet while in reset
`define UHFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds through reset
`define UHFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/uhfr_pkg.sv
// Shared types, character codes and helpers of the frame receiver
package uhfr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 256;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd50;

  // framing characters
  localparam logic [7:0] CH_E  = 8'h65;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_CR = 8'h0d;

  localparam logic [7:0] HEX_DIGIT0 = 8'h30;
  localparam logic [7:0] HEX_UPPER  = 8'h41;
  localparam logic [7:0] HEX_LOWER  = 8'h61;

  // hex frame layout: two header chars, four length digits, payload, four CRC digits
  localparam int unsigned HEX_DATA_START = 6;
  localparam int unsigned HEX_CRC_DIGITS = 4;
  localparam int unsigned HEX_HEADROOM   = 10;

  localparam int unsigned DLEN_W = 16;
  localparam int unsigned LIM_W  = DLEN_W + 1;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    FT_NONE = 2'd0,
    FT_HEX  = 2'd1,
    FT_TEXT = 2'd2
  } frame_type_e;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HDR  = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_TEXT = 6'b100000
  } phase_e;

  typedef struct packed {
    logic wr_en;
    logic bank_swap;
  } uhfr_wr_t;

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= HEX_DIGIT0 && c <= HEX_DIGIT0 + 8'd9) begin
      v = 4'(c - HEX_DIGIT0);
    end else if (c >= HEX_UPPER && c <= HEX_UPPER + 8'd5) begin
      v = 4'(c - HEX_UPPER + 8'd10);
    end else if (c >= HEX_LOWER && c <= HEX_LOWER + 8'd5) begin
      v = 4'(c - HEX_LOWER + 8'd10);
    end
    return v;
  endfunction

  function automatic logic is_header_char(logic [7:0] c);
    return (c == CH_E) || (c == CH_A) || (c == CH_R) || (c == CH_T);
  endfunction

endpackage

FILE: rtl/uhfr_req_if.sv
// Request channel: received bytes, timeout ticks and payload reads
interface uhfr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, req_type, rx_byte, read_index, input ready);
  modport sink   (input valid, req_type, rx_byte, read_index, output ready);
endinterface

FILE: rtl/uhfr_rsp_if.sv
// Result channel: frame status and read data
interface uhfr_rsp_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic        frame_aborted;
  logic [1:0]  frame_type;
  logic [7:0]  frame_length;
  logic [15:0] frame_crc;
  logic [7:0]  read_data;

  modport source (output valid, frame_done, frame_aborted, frame_type, frame_length,
                  frame_crc, read_data, input ready);
  modport sink   (input valid, frame_done, frame_aborted, frame_type, frame_length,
                  frame_crc, read_data, output ready);
endinterface

FILE: rtl/uhfr_cfg_if.sv
// Configuration write channel carrying the timeout limit
interface uhfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_limit;

  modport source (output valid, timeout_limit, input ready);
  modport sink   (input valid, timeout_limit, output ready);
endinterface

FILE: rtl/uart_hex_frame_receiver_top.sv
// A request's result is registered in the output register in the cycle after its transfer.
// Throughput: one request per cycle if results are taken; one memory write and read a cycle.
// Completed frames swap the two memory banks, so results are never held up by a copy.
// Reset: framing state, frame info and output valid clear; timeout limit returns to 50.
// The payload memory is not cleared: only bytes of the last completed frame are read.
module uart_hex_frame_receiver_top #(
  parameter int unsigned BUFFER_BYTES = uhfr_pkg::BUFFER_BYTES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  uhfr_req_if.sink   req_i,
  uhfr_rsp_if.source rsp_o,
  uhfr_cfg_if.sink   cfg_i
);
  import uhfr_pkg::*;

  `include "uart_hex_frame_receiver_top_defines.svh"

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = (AW > 8) ? AW : 8;

  logic          req_xfer;
  logic          byte_en, tick_en, read_en;
  logic [15:0]   limit_q;
  logic          rsp_valid_q;
  logic          done_q, aborted_q, hit_q;
  logic          done_c, aborted_c;
  uhfr_wr_t      wr_ctrl;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [1:0]    done_type;
  logic [AW-1:0] done_len;
  logic [15:0]   done_crc;
  logic [CW-1:0] len_x, idx_x;
  logic [AW-1:0] rd_addr;
  logic          rd_hit;
  logic [7:0]    rd_data;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign byte_en     = req_xfer && (req_i.req_type == REQ_BYTE);
  assign tick_en     = req_xfer && (req_i.req_type == REQ_TICK);
  assign read_en     = req_xfer && (req_i.req_type == REQ_READ);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.timeout_limit;
    end
  end

  uhfr_frame #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_en_i       (byte_en),
    .tick_en_i       (tick_en),
    .rx_byte_i       (req_i.rx_byte),
    .timeout_limit_i (limit_q),
    .done_o          (done_c),
    .aborted_o       (aborted_c),
    .wr_ctrl_o       (wr_ctrl),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .done_type_o     (done_type),
    .done_len_o      (done_len),
    .done_crc_o      (done_crc)
  );

  // hex payload starts after header and length digits
  assign len_x   = CW'(done_len);
  assign idx_x   = CW'(req_i.read_index);
  assign rd_hit  = idx_x < len_x;
  assign rd_addr = AW'(idx_x) + ((done_type == FT_HEX) ? AW'(HEX_DATA_START) : AW'(0));

  uhfr_store #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_ctrl_i (wr_ctrl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (read_en && rd_hit),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_xfer) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      done_q    <= done_c;
      aborted_q <= aborted_c;
      hit_q     <= read_en && rd_hit;
    end
  end

  // frame info registers change only on a transfer, together with the result
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.frame_done    = done_q;
  assign rsp_o.frame_aborted = aborted_q;
  assign rsp_o.frame_type    = done_type;
  assign rsp_o.frame_length  = len_x[7:0];
  assign rsp_o.frame_crc     = done_crc;
  assign rsp_o.read_data     = hit_q ? rd_data : 8'd0;

  `UHFR_ASSERT(a_xfer_gives_result, req_xfer |=> rsp_valid_q, "transfer lost its result")
  `UHFR_ASSERT(a_done_not_aborted, rsp_valid_q |-> !(done_q && aborted_q),
               "frame both completed and aborted")
  `UHFR_ASSERT(a_done_has_type, (rsp_valid_q && done_q) |-> (done_type != FT_NONE),
               "completed frame without type")
  `UHFR_ASSERT_ALWAYS(a_no_swap_without_done, wr_ctrl.bank_swap |-> done_c,
                      "bank swap outside frame completion")

endmodule

FILE: rtl/uhfr_store.sv
// Two-bank payload memory: one bank fills while the other holds the last frame
module uhfr_store #(
  parameter int unsigned BUFFER_BYTES = uhfr_pkg::BUFFER_BYTES_DEF,
  localparam int unsigned AW = $clog2(BUFFER_BYTES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uhfr_pkg::uhfr_wr_t wr_ctrl_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [7:0]         wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [7:0]         rd_data_o
);
  import uhfr_pkg::*;

  localparam int unsigned DEPTH = 2 * (1 << AW);

  logic [7:0] mem_q [DEPTH];
  logic       bank_q;
  logic       bank_d;
  logic [7:0] rd_data_q;

  assign bank_d = wr_ctrl_i.bank_swap ? ~bank_q : bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
    end else begin
      bank_q <= bank_d;
    end
  end

  // receive bank is bank_q, completed frame sits in the other one
  always_ff @(posedge clk_i) begin
    if (wr_ctrl_i.wr_en) begin
      mem_q[{bank_q, wr_addr_i}] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[{~bank_q, rd_addr_i}];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/uhfr_frame.sv
// Framing state machine: header match, length and CRC decode, timeout
module uhfr_frame #(
  parameter int unsigned BUFFER_BYTES = uhfr_pkg::BUFFER_BYTES_DEF,
  localparam int unsigned AW = $clog2(BUFFER_BYTES),
  localparam int unsigned PW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_en_i,
  input  logic               tick_en_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [15:0]        timeout_limit_i,
  output logic               done_o,
  output logic               aborted_o,
  output uhfr_pkg::uhfr_wr_t wr_ctrl_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [7:0]         wr_data_o,
  output logic [1:0]         done_type_o,
  output logic [AW-1:0]      done_len_o,
  output logic [15:0]        done_crc_o
);
  import uhfr_pkg::*;

  phase_e            phase_q, phase_d;
  logic [7:0]        first_q, first_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [DLEN_W-1:0] dlen_q, dlen_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       ticks_q, ticks_d;
  frame_type_e       done_type_q, done_type_d;
  logic [AW-1:0]     done_len_q, done_len_d;
  logic [15:0]       done_crc_q, done_crc_d;

  logic [3:0]        hexv;
  logic [LIM_W-1:0]  pos_x, pos_inc, data_lim, crc_lim;
  logic [DLEN_W-1:0] dlen_shift;
  logic [15:0]       crc_shift;
  logic [15:0]       tick_inc;

  assign hexv       = hex_value(rx_byte_i);
  assign pos_x      = LIM_W'(pos_q);
  assign pos_inc    = pos_x + LIM_W'(1);
  assign data_lim   = LIM_W'(dlen_q) + LIM_W'(HEX_DATA_START);
  assign crc_lim    = data_lim + LIM_W'(HEX_CRC_DIGITS);
  assign dlen_shift = {dlen_q[DLEN_W-5:0], hexv};
  assign crc_shift  = {crc_q[11:0], hexv};
  assign tick_inc   = ticks_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    first_d     = first_q;
    pos_d       = pos_q;
    dlen_d      = dlen_q;
    crc_d       = crc_q;
    ticks_d     = ticks_q;
    done_type_d = done_type_q;
    done_len_d  = done_len_q;
    done_crc_d  = done_crc_q;
    wr_ctrl_o   = '0;
    wr_addr_o   = pos_q[AW-1:0];
    wr_data_o   = rx_byte_i;
    done_o      = 1'b0;
    aborted_o   = 1'b0;

    if (byte_en_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (is_header_char(rx_byte_i)) begin
            first_d         = rx_byte_i;
            wr_ctrl_o.wr_en = 1'b1;
            wr_addr_o       = AW'(0);
            phase_d         = PH_HDR;
          end
        end
        PH_HDR: begin
          // an unmatched second char is dropped, the first one stays
          if (first_q == CH_E && rx_byte_i == CH_E) begin
            phase_d = PH_LEN;
          end else if ((first_q == CH_A || first_q == CH_R) && rx_byte_i == CH_T) begin
            phase_d = PH_TEXT;
          end
          if (phase_d != PH_HDR) begin
            wr_ctrl_o.wr_en = 1'b1;
            wr_addr_o       = AW'(1);
            ticks_d         = '0;
            pos_d           = PW'(2);
            dlen_d          = '0;
          end
        end
        PH_LEN: begin
          dlen_d = dlen_shift;
          pos_d  = PW'(pos_inc);
          if (pos_inc >= LIM_W'(HEX_DATA_START)) begin
            ticks_d = '0;
            crc_d   = '0;
            phase_d = (dlen_shift <= DLEN_W'(BUFFER_BYTES - HEX_HEADROOM)) ? PH_DATA : PH_IDLE;
          end
        end
        PH_DATA: begin
          ticks_d = '0;
          if (pos_x < data_lim) begin
            wr_ctrl_o.wr_en = 1'b1;
            pos_d           = PW'(pos_inc);
            if (pos_inc >= data_lim) begin
              phase_d = PH_CRC;
            end
          end else begin
            // empty payload: this byte is swallowed
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          if (pos_inc >= crc_lim) begin
            done_type_d         = FT_HEX;
            done_len_d          = dlen_q[AW-1:0];
            done_crc_d          = crc_shift;
            phase_d             = PH_IDLE;
            dlen_d              = '0;
            wr_ctrl_o.bank_swap = 1'b1;
            done_o              = 1'b1;
          end
          crc_d = crc_shift;
          pos_d = PW'(pos_inc);
        end
        PH_TEXT: begin
          // a full line ignores further bytes until a timeout
          if (pos_x < LIM_W'(BUFFER_BYTES - 1)) begin
            wr_ctrl_o.wr_en = 1'b1;
            pos_d           = PW'(pos_inc);
            ticks_d         = '0;
            if (rx_byte_i == CH_CR) begin
              done_type_d         = FT_TEXT;
              done_len_d          = pos_q[AW-1:0];
              phase_d             = PH_IDLE;
              dlen_d              = '0;
              wr_ctrl_o.bank_swap = 1'b1;
              done_o              = 1'b1;
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end else if (tick_en_i && phase_q != PH_IDLE) begin
      if (tick_inc > timeout_limit_i) begin
        phase_d   = PH_IDLE;
        dlen_d    = '0;
        ticks_d   = '0;
        pos_d     = '0;
        aborted_o = 1'b1;
      end else begin
        ticks_d = tick_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      first_q     <= '0;
      pos_q       <= '0;
      dlen_q      <= '0;
      crc_q       <= '0;
      ticks_q     <= '0;
      done_type_q <= FT_NONE;
      done_len_q  <= '0;
      done_crc_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      first_q     <= first_d;
      pos_q       <= pos_d;
      dlen_q      <= dlen_d;
      crc_q       <= crc_d;
      ticks_q     <= ticks_d;
      done_type_q <= done_type_d;
      done_len_q  <= done_len_d;
      done_crc_q  <= done_crc_d;
    end
  end

  assign done_type_o = done_type_q;
  assign done_len_o  = done_len_q;
  assign done_crc_o  = done_crc_q;

endmodule

FILE: dv/uart_hex_frame_receiver_top_test.sv
// Self-checking testbench for the hex/text frame receiver: queued stimulus, predictor, checker
module uart_hex_frame_receiver_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uhfr_pkg::*;

  localparam int unsigned BUF         = BUFFER_BYTES_DEF;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HDR, ST_LEN, ST_DATA, ST_CRC, ST_TEXT
  } frame_stage_e;

  typedef struct packed {
    req_e       kind;
    logic [7:0] rx_byte;
    logic [7:0] index;
  } uhfr_request_t;

  typedef struct packed {
    logic        done;
    logic        aborted;
    frame_type_e ftype;
    logic [7:0]  flen;
    logic [15:0] crc;
    logic [7:0]  rdata;
  } frame_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  uhfr_req_if req_bus ();
  uhfr_rsp_if rsp_bus ();
  uhfr_cfg_if cfg_bus ();

  uart_hex_frame_receiver_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  frame_stage_e rx_state   = ST_IDLE;
  logic [7:0]   first_char = 8'd0;
  int unsigned  byte_pos   = 0;
  logic [15:0]  decl_len   = 16'd0;
  logic [15:0]  crc_acc    = 16'd0;
  logic [15:0]  tick_count = 16'd0;
  logic [15:0]  cur_limit  = TIMEOUT_RESET;
  logic [7:0]   rx_buf   [BUF];
  logic [7:0]   held_buf [BUF];
  frame_type_e  held_type = FT_NONE;
  int unsigned  held_len  = 0;
  logic [15:0]  held_crc  = 16'd0;

  uhfr_request_t pending_requests [$];
  frame_status_t status_expected [$];
  uhfr_request_t next_req;
  frame_status_t got_status;
  frame_status_t want_status;

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count     = 0;
  int unsigned stall_cycles   = 0;
  logic [15:0] limit_setting  = TIMEOUT_RESET;
  bit          req_taken      = 1'b0;
  bit          no_idle        = 1'b0;
  bit          sink_hold      = 1'b0;
  bit          hold_request   = 1'b0;

  function automatic logic [3:0] nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
    return 4'd0;
  endfunction

  function automatic bit framing_char(logic [7:0] c);
    return c == CH_E || c == CH_A || c == CH_R || c == CH_T;
  endfunction

  function automatic bit take_rx_char(logic [7:0] c);
    int unsigned i;
    bit fin;
    fin = 1'b0;
    case (rx_state)
      ST_IDLE, ST_HDR: begin
        if (framing_char(c)) begin
          if (rx_state == ST_IDLE) begin
            first_char = c;
            rx_buf[0]  = c;
            rx_state   = ST_HDR;
          end else if ((first_char == CH_E && c == CH_E) ||
                       ((first_char == CH_A || first_char == CH_R) && c == CH_T)) begin
            rx_state   = (c == CH_E) ? ST_LEN : ST_TEXT;
            rx_buf[1]  = c;
            tick_count = 16'd0;
            byte_pos   = 2;
            decl_len   = 16'd0;
          end
          // an unmatched second char is dropped, the first one stays
        end
      end
      ST_LEN: begin
        decl_len = {decl_len[11:0], nibble_of(c)};
        byte_pos++;
        if (byte_pos >= HEX_DATA_START) begin
          tick_count = 16'd0;
          crc_acc    = 16'd0;
          rx_state   = (decl_len <= BUF - HEX_HEADROOM) ? ST_DATA : ST_IDLE;
        end
      end
      ST_DATA: begin
        tick_count = 16'd0;
        if (byte_pos < decl_len + HEX_DATA_START) begin
          rx_buf[byte_pos % BUF] = c;
          byte_pos++;
        end
        // a zero length still swallows one byte here
        if (byte_pos >= decl_len + HEX_DATA_START) rx_state = ST_CRC;
      end
      ST_CRC: begin
        if (byte_pos < decl_len + HEX_HEADROOM) begin
          crc_acc = {crc_acc[11:0], nibble_of(c)};
          byte_pos++;
        end
        if (byte_pos >= decl_len + HEX_HEADROOM) begin
          for (i = 0; i < decl_len && i < BUF; i++)
            held_buf[i] = rx_buf[(HEX_DATA_START + i) % BUF];
          held_type = FT_HEX;
          held_len  = decl_len;
          held_crc  = crc_acc;
          rx_state  = ST_IDLE;
          decl_len  = 16'd0;
          fin       = 1'b1;
        end
      end
      ST_TEXT: begin
        // a full line ignores everything until a timeout
        if (byte_pos < BUF - 1) begin
          rx_buf[byte_pos] = c;
          byte_pos++;
          tick_count = 16'd0;
          if (c == CH_CR) begin
            for (i = 0; i + 1 < byte_pos; i++) held_buf[i] = rx_buf[i];
            held_type = FT_TEXT;
            held_len  = byte_pos - 1;
            rx_state  = ST_IDLE;
            decl_len  = 16'd0;
            fin       = 1'b1;
          end
        end
      end
      default: rx_state = ST_IDLE;
    endcase
    return fin;
  endfunction

  function automatic bit take_tick();
    if (rx_state == ST_IDLE) return 1'b0;
    tick_count = tick_count + 16'd1;
    if (tick_count > cur_limit) begin
      rx_state   = ST_IDLE;
      decl_len   = 16'd0;
      tick_count = 16'd0;
      byte_pos   = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic frame_status_t step_receiver(uhfr_request_t rq);
    frame_status_t r;
    r = '0;
    case (rq.kind)
      REQ_BYTE: r.done = take_rx_char(rq.rx_byte);
      REQ_TICK: r.aborted = take_tick();
      REQ_READ: if (rq.index < held_len) r.rdata = held_buf[rq.index];
      default: ;
    endcase
    r.ftype = held_type;
    r.flen  = held_len[7:0];
    r.crc   = held_crc;
    return r;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!req_bus.valid || req_taken)) begin
      req_taken = 1'b0;
      if (pending_requests.size() != 0 && (no_idle || $urandom_range(99) >= 16)) begin
        next_req = pending_requests.pop_front();
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= next_req.kind;
        req_bus.rx_byte    <= next_req.rx_byte;
        req_bus.read_index <= next_req.index;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (rst_ni) rsp_bus.ready <= !sink_hold && (no_idle || $urandom_range(99) >= 16);
  end

  // transfer monitor, checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cycles++;
      if (req_bus.valid && req_bus.ready) begin
        req_taken = 1'b1;
        accepted_count++;
        stall_cycles = 0;
        status_expected.push_back(step_receiver(
          {req_e'(req_bus.req_type), req_bus.rx_byte, req_bus.read_index}));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        stall_cycles = 0;
        got_status = {rsp_bus.frame_done, rsp_bus.frame_aborted,
                      frame_type_e'(rsp_bus.frame_type), rsp_bus.frame_length,
                      rsp_bus.frame_crc, rsp_bus.read_data};
        if (status_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: done=%0d aborted=%0d type=%0d len=%0d crc=%h data=%h",
                     got_status.done, got_status.aborted, got_status.ftype,
                     got_status.flen, got_status.crc, got_status.rdata);
        end else begin
          want_status = status_expected.pop_front();
          if (got_status !== want_status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected done=%0d aborted=%0d type=%0d len=%0d crc=%h data=%h",
                       want_status.done, want_status.aborted, want_status.ftype,
                       want_status.flen, want_status.crc, want_status.rdata);
              $display("          got      done=%0d aborted=%0d type=%0d len=%0d crc=%h data=%h",
                       got_status.done, got_status.aborted, got_status.ftype,
                       got_status.flen, got_status.crc, got_status.rdata);
            end
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        stall_cycles = 0;
        cur_limit = cfg_bus.timeout_limit;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (hold_request);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  task automatic queue_request(req_e k, logic [7:0] b, logic [7:0] ix);
    pending_requests.push_back('{kind: k, rx_byte: b, index: ix});
    queued_count++;
  endtask

  task automatic queue_byte(logic [7:0] c);
    queue_request(REQ_BYTE, c, 8'($urandom_range(255)));
  endtask

  task automatic queue_tick();
    queue_request(REQ_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic queue_read(logic [7:0] ix);
    queue_request(REQ_READ, 8'($urandom_range(255)), ix);
  endtask

  task automatic maybe_tick(int unsigned pct);
    if ($urandom_range(99) < pct) queue_tick();
  endtask

  // zero digits are sometimes sent as non-hex characters, which decode the same
  function automatic logic [7:0] hex_char(logic [3:0] v, bit junk_ok);
    if (junk_ok && v == 4'd0 && $urandom_range(7) == 0) begin
      case ($urandom_range(5))
        0: return 8'h2f;
        1: return 8'h3a;
        2: return 8'h40;
        3: return 8'h47;
        4: return 8'h60;
        default: return 8'h67;
      endcase
    end
    if (v < 4'd10) return 8'(HEX_DIGIT0 + v);
    return 8'(($urandom_range(1) ? HEX_UPPER : HEX_LOWER) + (v - 4'd10));
  endfunction

  task automatic queue_hex_frame(logic [15:0] len_field, int unsigned tick_pct);
    int unsigned body;
    logic [15:0] crc_val;
    crc_val = 16'($urandom_range(65535));
    queue_byte(CH_E);
    queue_byte(CH_E);
    for (int d = 3; d >= 0; d--) begin
      maybe_tick(tick_pct);
      queue_byte(hex_char(len_field[d*4 +: 4], 1'b1));
    end
    if (len_field <= BUF - HEX_HEADROOM) begin
      body = (len_field == 16'd0) ? 1 : len_field;
      repeat (body) begin
        maybe_tick(tick_pct);
        queue_byte(8'($urandom_range(255)));
      end
      for (int d = 3; d >= 0; d--) begin
        maybe_tick(tick_pct);
        queue_byte(hex_char(crc_val[d*4 +: 4], 1'b1));
      end
    end
  endtask

  task automatic queue_text_line(logic [7:0] lead, int unsigned body, bit terminate,
                                 int unsigned tick_pct);
    logic [7:0] b;
    queue_byte(lead);
    queue_byte(CH_T);
    repeat (body) begin
      do b = 8'($urandom_range(255)); while (b == CH_CR);
      maybe_tick(tick_pct);
      queue_byte(b);
    end
    if (terminate) queue_byte(CH_CR);
  endtask

  task automatic queue_broken_frame();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: queue_byte(CH_E);
          1: queue_byte(CH_A);
          2: queue_byte(CH_R);
          default: queue_byte(CH_T);
        endcase
      end
      1: begin
        queue_byte(CH_E);
        queue_byte(CH_E);
        repeat ($urandom_range(3)) queue_byte(hex_char(4'($urandom_range(15)), 1'b1));
      end
      2: begin
        queue_byte(CH_E);
        queue_byte(CH_E);
        queue_byte("0");
        queue_byte("0");
        queue_byte("1");
        queue_byte("0");
        repeat ($urandom_range(8)) queue_byte(8'($urandom_range(255)));
      end
      default: queue_text_line($urandom_range(1) ? CH_A : CH_R, $urandom_range(8), 1'b0, 0);
    endcase
    if (limit_setting <= 16'd60) repeat (int'(limit_setting) + 1) queue_tick();
    else repeat (3) queue_tick();
  endtask

  task automatic gen_traffic(int unsigned target, int unsigned tick_pct);
    int unsigned counted;
    int unsigned mark;
    int unsigned sel;
    int unsigned n;
    counted = 0;
    while (counted < target) begin
      mark = queued_count;
      sel  = $urandom_range(99);
      if (sel < 38) begin
        n = $urandom_range(12);
        if ($urandom_range(19) == 0) n = $urandom_range(246, 200);
        else if ($urandom_range(14) == 0) n = $urandom_range(65535, 247);
        queue_hex_frame(16'(n), tick_pct);
      end else if (sel < 58) begin
        n = ($urandom_range(24) == 0) ? $urandom_range(252, 240) : $urandom_range(16);
        queue_text_line($urandom_range(1) ? CH_A : CH_R, n, 1'b1, tick_pct);
      end else if (sel < 76) begin
        repeat ($urandom_range(4, 1))
          queue_read($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(15)));
      end else if (sel < 84) begin
        repeat ($urandom_range(3, 1)) queue_tick();
      end else if (sel < 92) begin
        repeat ($urandom_range(3, 1)) begin
          if ($urandom_range(3) == 0)
            queue_request(REQ_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)));
          else
            queue_byte(8'($urandom_range(255)));
        end
        mark = queued_count;  // noise is not counted
      end else begin
        queue_broken_frame();
      end
      counted += queued_count - mark;
    end
  endtask

  // sender pause: wait until every request has been answered
  task automatic drain();
    while (accepted_count != queued_count || status_expected.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_timeout_limit(logic [15:0] v);
    @(negedge clk_i);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.timeout_limit <= v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    limit_setting = v;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] phase_limits [8];

    req_bus.valid         = 1'b0;
    req_bus.req_type      = REQ_BYTE;
    req_bus.rx_byte       = 8'd0;
    req_bus.read_index    = 8'd0;
    rsp_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.timeout_limit = 16'd0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle requests straight after reset
    queue_tick();
    queue_read(8'd0);
    queue_read(8'd255);
    queue_request(REQ_NONE, 8'hff, 8'hff);
    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_byte(CH_CR);
    // unmatched pair, then a hex frame with a non-hex length digit
    queue_byte(CH_E);
    queue_byte(CH_A);
    queue_byte(CH_E);
    queue_byte("0");
    queue_byte("0");
    queue_byte(":");
    queue_byte("3");
    queue_byte("a");
    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_byte("f");
    queue_byte("F");
    queue_byte("9");
    queue_byte("g");
    queue_read(8'd0);
    queue_read(8'd2);
    queue_read(8'd3);
    // empty payload: one byte dropped before the CRC
    queue_byte(CH_E);
    queue_byte(CH_E);
    repeat (4) queue_byte("0");
    queue_byte("Z");
    queue_byte("A");
    queue_byte("b");
    queue_byte("C");
    queue_byte("d");
    // text lines
    queue_byte(CH_A);
    queue_byte(CH_R);
    queue_byte(CH_T);
    queue_byte("o");
    queue_byte("k");
    queue_byte(CH_CR);
    for (int i = 0; i < 5; i++) queue_read(8'(i));
    queue_byte(CH_R);
    queue_byte(CH_T);
    queue_byte(CH_CR);
    queue_read(8'd1);
    // oversize lengths
    queue_hex_frame(16'd247, 0);
    queue_hex_frame(16'hffff, 0);
    // a lone T header can only be cleared by timeout
    queue_byte(CH_T);
    queue_byte(CH_T);
    repeat (51) queue_tick();
    drain();

    write_timeout_limit(16'd0);
    queue_byte(CH_E);
    queue_byte(CH_E);
    queue_tick();
    queue_tick();
    drain();

    write_timeout_limit(16'd3);
    // full text line, its CR ignored, then discarded by timeout
    queue_text_line(CH_A, 253, 1'b0, 0);
    queue_byte(CH_CR);
    repeat (4) queue_tick();
    queue_text_line(CH_R, 252, 1'b1, 0);
    queue_read(8'd253);
    queue_read(8'd254);
    queue_hex_frame(16'd246, 0);
    queue_read(8'd245);
    queue_read(8'd246);
    drain();

    write_timeout_limit(16'hffff);
    queue_hex_frame(16'd2, 30);
    queue_read(8'd1);
    drain();

    phase_limits[0] = TIMEOUT_RESET;
    phase_limits[1] = 16'd0;
    phase_limits[2] = 16'hffff;
    phase_limits[3] = 16'd1;
    phase_limits[4] = 16'd7;
    phase_limits[5] = 16'($urandom_range(40, 2));
    phase_limits[6] = 16'd25;
    phase_limits[7] = 16'($urandom_range(65535));

    for (int p = 0; p < 8; p++) begin
      write_timeout_limit(phase_limits[p]);
      no_idle = (p == 2);
      gen_traffic((p == 2) ? 48 : 8, (p == 1) ? 1 : 3);
      if (p == 3) hold_request = 1'b1;
      drain();
    end
    no_idle = 1'b0;

    drain();
    if (fail_count == 0 && status_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: uart_hex_frame_receiver_top.f
+incdir+rtl
rtl/uhfr_pkg.sv
rtl/uhfr_req_if.sv
rtl/uhfr_rsp_if.sv
rtl/uhfr_cfg_if.sv
rtl/uhfr_store.sv
rtl/uhfr_frame.sv
rtl/uart_hex_frame_receiver_top.sv
dv/uart_hex_frame_receiver_top_test.sv
